>>> rtl/chacha_pkg.sv
// Shared types and constants for the ChaCha stream cipher block.
// Used by chacha_half_round, chacha_core and chacha_stream_cipher_top.
package chacha_pkg;

  typedef logic [15:0][31:0] state_t;

  // One step of the shared unit: which half of a quarter round and which
  // round type (column or diagonal) the four lanes work on.
  typedef struct packed {
    logic half;
    logic diag;
  } step_sel_t;

  typedef struct packed {
    logic       start;
    logic [4:0] dbl_rounds;
  } core_ctrl_t;

  localparam logic [3:0][31:0] SIGMA32 = {32'h6b206574, 32'h79622d32,
                                          32'h3320646e, 32'h61707865};
  localparam logic [3:0][31:0] SIGMA16 = {32'h6b206574, 32'h79622d36,
                                          32'h3120646e, 32'h61707865};

  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_NONCE  = 3'd4;
  localparam logic [2:0] REG_MODE   = 3'd5;
  localparam logic [2:0] REG_ROUNDS = 3'd6;

endpackage

>>> rtl/chacha_half_round.sv
// Shared arithmetic unit: half of a quarter round on four lanes at once.
// Depends on chacha_pkg for state_t and step_sel_t.
module chacha_half_round
  import chacha_pkg::*;
(
  input  state_t    w_in,
  input  step_sel_t sel,
  output state_t    w_out
);

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  logic [1:0] off_b, off_c, off_d;

  assign off_b = sel.diag ? 2'd1 : 2'd0;
  assign off_c = sel.diag ? 2'd2 : 2'd0;
  assign off_d = sel.diag ? 2'd3 : 2'd0;

  always_comb begin
    logic [3:0]  ai, bi, ci, di;
    logic [31:0] a, b, c, d, dx, bx;
    w_out = w_in;
    for (int i = 0; i < 4; i++) begin
      ai = {2'b00, 2'(i)};
      bi = {2'b01, 2'(i) + off_b};
      ci = {2'b10, 2'(i) + off_c};
      di = {2'b11, 2'(i) + off_d};
      a  = w_in[ai] + w_in[bi];
      dx = w_in[di] ^ a;
      d  = sel.half ? rotl32(dx, 8) : rotl32(dx, 16);
      c  = w_in[ci] + d;
      bx = w_in[bi] ^ c;
      b  = sel.half ? rotl32(bx, 7) : rotl32(bx, 12);
      w_out[ai] = a;
      w_out[bi] = b;
      w_out[ci] = c;
      w_out[di] = d;
    end
  end

endmodule

>>> rtl/chacha_core.sv
// Block function sequencer: runs the double rounds on the shared half-round
// unit and adds the input state. Depends on chacha_pkg and chacha_half_round.
module chacha_core
  import chacha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  core_ctrl_t ctrl,
  input  state_t     in_state,
  output logic       done,
  output state_t     keystream
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_FINAL = 3'b100
  } core_state_t;

  core_state_t state;
  state_t      work;
  state_t      work_next;
  logic [4:0]  dr_left;
  logic [1:0]  sub;
  step_sel_t   sel;

  // sub[0] picks the half, sub[1] the diagonal round
  assign sel.half = sub[0];
  assign sel.diag = sub[1];

  chacha_half_round u_half (
    .w_in  (work),
    .sel   (sel),
    .w_out (work_next)
  );

  assign done = (state == C_FINAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      dr_left <= '0;
      sub     <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          if (ctrl.start) begin
            work    <= in_state;
            dr_left <= ctrl.dbl_rounds;
            sub     <= '0;
            state   <= (ctrl.dbl_rounds == 5'd0) ? C_FINAL : C_ROUND;
          end
        end
        C_ROUND: begin
          work <= work_next;
          sub  <= sub + 2'd1;
          if (sub == 2'd3) begin
            dr_left <= dr_left - 5'd1;
            if (dr_left == 5'd1) state <= C_FINAL;
          end
        end
        C_FINAL: begin
          for (int i = 0; i < 16; i++) keystream[i] <= work[i] + in_state[i];
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/chacha_stream_cipher_top.sv
// Top level of the ChaCha stream cipher: configuration registers, block
// counter, word position and output register. Depends on chacha_pkg, chacha_core.
//
// Usage:
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   key words 0..3, nonce, key size mode and round count at indexes 0..6.
//   cfg_ready is tied high; user writes only while the block is idle, unchecked.
//   Any write to indexes 0..6 restarts the keystream at block counter 0.
//   Input channel (in_valid/in_ready, message_word) takes one 64-bit word
//   per beat; output channel (out_valid/out_ready, cipher_word, block_end)
//   returns the XORed word, block_end high on the eighth word of a block.
//   The first word of each block waits for the block function in chacha_core,
//   which registers the keystream, then for the S_EMIT step before out_valid;
//   the half-round unit runs one half quarter round per cycle on four lanes.
//   The other seven words leave in the cycle after their beat.
//   in_ready is low while a block is computed and while an undelivered
//   result sits in the output register with out_ready low.
//   Reset (rst, synchronous) restores key size mode 1, 20 rounds, zero keys,
//   nonce and counter, and empties the output register.
module chacha_stream_cipher_top
  import chacha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] message_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] cipher_word,
  output logic        block_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_GEN  = 3'b010,
    S_EMIT = 3'b100
  } top_state_t;

  top_state_t  state;
  logic [63:0] key0, key1, key2, key3, nonce_reg;
  logic        key_mode;
  logic [4:0]  rounds;
  logic [63:0] counter;
  logic [2:0]  position;
  logic [63:0] msg_hold;

  state_t      in_state;
  state_t      keystream;
  core_ctrl_t  ctrl;
  logic        core_done;
  logic        in_fire;
  logic        out_load;
  logic [5:0]  rounds_inc;
  logic [63:0] k2, k3;
  logic [63:0] ks_word;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state == S_EMIT) || (in_fire && (position != 3'd0));

  assign rounds_inc = {1'b0, rounds} + 6'd1;
  assign ctrl.start      = in_fire && (position == 3'd0);
  assign ctrl.dbl_rounds = rounds_inc[5:1];

  assign k2 = key_mode ? key2 : key0;
  assign k3 = key_mode ? key3 : key1;

  always_comb begin
    for (int i = 0; i < 4; i++) in_state[i] = key_mode ? SIGMA32[i] : SIGMA16[i];
    in_state[4]  = key0[31:0];
    in_state[5]  = key0[63:32];
    in_state[6]  = key1[31:0];
    in_state[7]  = key1[63:32];
    in_state[8]  = k2[31:0];
    in_state[9]  = k2[63:32];
    in_state[10] = k3[31:0];
    in_state[11] = k3[63:32];
    in_state[12] = counter[31:0];
    in_state[13] = counter[63:32];
    in_state[14] = nonce_reg[31:0];
    in_state[15] = nonce_reg[63:32];
  end

  assign ks_word = {keystream[{position, 1'b1}], keystream[{position, 1'b0}]};

  chacha_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_state  (in_state),
    .done      (core_done),
    .keystream (keystream)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key0      <= '0;
      key1      <= '0;
      key2      <= '0;
      key3      <= '0;
      nonce_reg <= '0;
      key_mode  <= 1'b1;
      rounds    <= 5'd20;
      counter   <= '0;
      position  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY0:   key0      <= cfg_data;
          REG_KEY1:   key1      <= cfg_data;
          REG_KEY2:   key2      <= cfg_data;
          REG_KEY3:   key3      <= cfg_data;
          REG_NONCE:  nonce_reg <= cfg_data;
          REG_MODE:   key_mode  <= cfg_data[0];
          REG_ROUNDS: rounds    <= cfg_data[4:0];
          default: ;
        endcase
        if (cfg_index <= REG_ROUNDS) begin
          counter  <= '0;
          position <= '0;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (position == 3'd0) begin
              msg_hold <= message_word;
              state    <= S_GEN;
            end else begin
              cipher_word <= message_word ^ ks_word;
              block_end   <= (position == 3'd7);
              position    <= position + 3'd1;
            end
          end
        end
        S_GEN: begin
          if (core_done) begin
            counter <= counter + 64'd1;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          // keystream now holds the new block; position is still zero
          cipher_word <= msg_hold ^ ks_word;
          block_end   <= 1'b0;
          position    <= position + 3'd1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
